@@ rtl/core/c_style_byte_tokenizer_top_defines.svh @@
// Assertion helpers for the byte tokenizer.
`ifndef C_STYLE_BYTE_TOKENIZER_TOP_DEFINES_SVH
`define C_STYLE_BYTE_TOKENIZER_TOP_DEFINES_SVH

// same-cycle implication
`define CBT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CBT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/cbt_pkg.sv @@
`timescale 1ns / 1ps

package cbt_pkg;

  localparam int POS_W   = 16;
  localparam int QDEPTH  = 4;
  localparam int CNT_W   = $clog2(QDEPTH + 1);
  localparam int OUT_TDATA_W = 48;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_WORD,
    MODE_LINE,
    MODE_BLOCK,
    MODE_STRING
  } scan_mode_t;

  typedef enum logic [2:0] {
    CLS_SPACE,
    CLS_COMMENT,
    CLS_STRING,
    CLS_PAIR_OP,
    CLS_PUNCT,
    CLS_WORD
  } byte_class_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_BLOCK,
    ERR_STRING
  } err_code_t;

  typedef struct packed {
    scan_mode_t       mode;
    logic             quote_single;
    logic [7:0]       held_byte;
    logic             held_valid;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] open_line;
    logic [POS_W-1:0] open_col;
    logic             error_seen;
  } scan_state_t;

  typedef struct packed {
    logic [7:0]  data;
    byte_class_t cls;
    logic        tok_start;
    err_code_t   err_code;
    logic [15:0] err_line;
    logic [15:0] err_col;
    logic        last;
  } res_t;

  typedef struct packed {
    scan_state_t s;
    res_t        r0;
    res_t        r1;
    logic [1:0]  cnt;
    logic        took;
    err_code_t   err;
  } lab_t;

  localparam scan_state_t STATE_RESET = '{
    mode:         MODE_NORMAL,
    quote_single: 1'b0,
    held_byte:    8'h00,
    held_valid:   1'b0,
    line:         POS_W'(1),
    col:          POS_W'(1),
    open_line:    POS_W'(1),
    open_col:     POS_W'(1),
    error_seen:   1'b0
  };

endpackage

@@ rtl/core/c_style_byte_tokenizer_top.sv @@
`timescale 1ns / 1ps
`include "c_style_byte_tokenizer_top_defines.svh"

// channel  dir  width            fields
// s_*      in   tdata 8, tlast   in_byte / end_of_source
// m_*      out  tdata 48, tlast  out_byte..error_column / last
//
// One input beat per cycle while s_tready is high. Each byte is labeled when the
// next one arrives, so its result trails by one beat (the final byte is labeled at once).
// A beat gives zero, one or two results into a 4-entry result queue; output drains
// one result per cycle while m_tready is high, and s_tready holds while at most 2 are
// queued. A byte pair therefore leaves as two output beats. Synchronous active-high rst
// returns all scan state to line 1, column 1 and empties the queue.
module c_style_byte_tokenizer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // end_of_source
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [cbt_pkg::OUT_TDATA_W-1:0] m_tdata,
                                 // [7:0] out_byte, [10:8] byte_class, [11] token_start,
                                 // [13:12] error_code, [29:14] error_line,
                                 // [45:30] error_column, [47:46] zero
  output logic        m_tlast    // last
);
  import cbt_pkg::*;

  scan_state_t      state, state_next;
  res_t             q [QDEPTH];
  res_t             q_next [QDEPTH];
  logic [CNT_W-1:0] count, count_next;
  logic             accept, pop;
  res_t             res0, res1;
  logic [1:0]       res_cnt;

  function automatic logic is_space(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == "(" || c == ")" ||
           c == "{" || c == "}" || c == "[" || c == "]" || c == ";" || c == "," ||
           c == "<" || c == ">" || c == "=" || c == "!" || c == ":";
  endfunction

  function automatic logic is_break(logic [7:0] c);
    return is_space(c) || c == CH_DQUOTE || is_punct(c);
  endfunction

  function automatic logic is_pair_op(logic [7:0] a, logic [7:0] b);
    if (b == CH_EQ) begin
      return a == "=" || a == "!" || a == "<" || a == ">" || a == "+" ||
             a == "-" || a == "*" || a == "/" || a == CH_PCT;
    end
    return a == b && (a == "&" || a == "|" || a == "+" || a == "-");
  endfunction

  function automatic logic [15:0] sat16(logic [POS_W-1:0] v);
    return (v > POS_W'(16'hFFFF)) ? 16'hFFFF : 16'(v);
  endfunction

  function automatic scan_state_t advance(scan_state_t s, logic [7:0] c);
    scan_state_t o;
    o = s;
    if (c == CH_LF) begin
      if (s.line != '1) o.line = s.line + POS_W'(1);
      o.col = POS_W'(1);
    end else if (s.col != '1) begin
      o.col = s.col + POS_W'(1);
    end
    return o;
  endfunction

  function automatic res_t mk_res(logic [7:0] c, byte_class_t cls, logic start);
    res_t r;
    r           = '0;
    r.data      = c;
    r.cls       = cls;
    r.tok_start = start;
    r.err_code  = ERR_NONE;
    return r;
  endfunction

  function automatic res_t finish(res_t r, err_code_t code, scan_state_t s);
    res_t o;
    o          = r;
    o.err_code = code;
    if (code != ERR_NONE) begin
      o.err_line = sat16(s.open_line);
      o.err_col  = sat16(s.open_col);
    end
    o.last = 1'b1;
    return o;
  endfunction

  // labels byte c with optional lookahead n; may consume n as the second half of a pair
  function automatic lab_t label_fn(scan_state_t s, logic [7:0] c, logic has_n,
                                    logic [7:0] n);
    lab_t       o;
    logic       normal;
    logic [7:0] qc;
    o      = '0;
    o.s    = s;
    o.err  = ERR_NONE;
    normal = 1'b0;
    qc     = s.quote_single ? CH_SQUOTE : CH_DQUOTE;
    unique case (s.mode)
      MODE_LINE: begin
        if (c != CH_LF) begin
          o.r0 = mk_res(c, CLS_COMMENT, 1'b0); o.s = advance(o.s, c); o.cnt = 2'd1;
        end else begin
          normal = 1'b1;
        end
      end
      MODE_WORD: begin
        if (!is_break(c)) begin
          o.r0 = mk_res(c, CLS_WORD, 1'b0); o.s = advance(o.s, c); o.cnt = 2'd1;
        end else begin
          normal = 1'b1;
        end
      end
      MODE_BLOCK: begin
        o.r0 = mk_res(c, CLS_COMMENT, 1'b0); o.s = advance(o.s, c); o.cnt = 2'd1;
        if (c == CH_STAR && has_n && n == CH_SLASH) begin
          o.r1     = mk_res(n, CLS_COMMENT, 1'b0);
          o.s      = advance(o.s, n);
          o.cnt    = 2'd2;
          o.s.mode = MODE_NORMAL;
          o.took   = 1'b1;
        end
      end
      MODE_STRING: begin
        o.r0 = mk_res(c, CLS_STRING, 1'b0); o.s = advance(o.s, c); o.cnt = 2'd1;
        if (c == CH_BSLASH && has_n) begin
          // escape: keep both bytes raw
          o.r1   = mk_res(n, CLS_STRING, 1'b0);
          o.s    = advance(o.s, n);
          o.cnt  = 2'd2;
          o.took = 1'b1;
        end else if (c == qc) begin
          o.s.mode = MODE_NORMAL;
        end else if (c == CH_LF) begin
          o.err = ERR_STRING;
        end
      end
      default: normal = 1'b1;
    endcase

    if (normal) begin
      o.s.mode = MODE_NORMAL;
      if (is_space(c)) begin
        o.r0 = mk_res(c, CLS_SPACE, 1'b0); o.s = advance(o.s, c); o.cnt = 2'd1;
      end else if (c == CH_SLASH && has_n && (n == CH_SLASH || n == CH_STAR)) begin
        if (n == CH_STAR) begin
          o.s.open_line = o.s.line;
          o.s.open_col  = o.s.col;
          o.s.mode      = MODE_BLOCK;
        end else begin
          o.s.mode = MODE_LINE;
        end
        o.r0 = mk_res(c, CLS_COMMENT, 1'b0); o.s = advance(o.s, c);
        o.r1 = mk_res(n, CLS_COMMENT, 1'b0); o.s = advance(o.s, n);
        o.cnt  = 2'd2;
        o.took = 1'b1;
      end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
        o.s.open_line    = o.s.line;
        o.s.open_col     = o.s.col;
        o.s.quote_single = (c == CH_SQUOTE);
        o.s.mode         = MODE_STRING;
        o.r0 = mk_res(c, CLS_STRING, 1'b1); o.s = advance(o.s, c); o.cnt = 2'd1;
      end else if (has_n && is_pair_op(c, n)) begin
        o.r0 = mk_res(c, CLS_PAIR_OP, 1'b1); o.s = advance(o.s, c);
        o.r1 = mk_res(n, CLS_PAIR_OP, 1'b0); o.s = advance(o.s, n);
        o.cnt  = 2'd2;
        o.took = 1'b1;
      end else if (is_punct(c)) begin
        o.r0 = mk_res(c, CLS_PUNCT, 1'b1); o.s = advance(o.s, c); o.cnt = 2'd1;
      end else begin
        o.s.mode = MODE_WORD;
        o.r0 = mk_res(c, CLS_WORD, 1'b1); o.s = advance(o.s, c); o.cnt = 2'd1;
      end
    end
    return o;
  endfunction

  assign s_tready = (count <= CNT_W'(QDEPTH - 2));
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = (count != '0);
  assign pop      = m_tvalid && m_tready;

  always_comb begin
    scan_state_t s;
    lab_t        a, b;
    err_code_t   err;
    logic        took, done;
    s       = state;
    a       = '0;
    b       = '0;
    err     = ERR_NONE;
    took    = 1'b0;
    done    = 1'b0;
    res0    = '0;
    res1    = '0;
    res_cnt = 2'd0;
    if (accept) begin
      if (s.error_seen) begin
        // drop bytes until end of source
        if (s_tlast) s = STATE_RESET;
      end else begin
        if (s.held_valid) begin
          s.held_valid = 1'b0;
          a       = label_fn(s, s.held_byte, 1'b1, s_tdata);
          s       = a.s;
          res0    = a.r0;
          res1    = a.r1;
          res_cnt = a.cnt;
          took    = a.took;
          err     = a.err;
          if (err != ERR_NONE) begin
            done = 1'b1;
            res0 = finish(res0, err, s);
            if (s_tlast) s = STATE_RESET;
            else s.error_seen = 1'b1;
          end
        end
        if (!done) begin
          if (!took) begin
            if (!s_tlast) begin
              s.held_byte  = s_tdata;
              s.held_valid = 1'b1;
            end else begin
              b   = label_fn(s, s_tdata, 1'b0, 8'h00);
              s   = b.s;
              err = b.err;
              if (res_cnt == 2'd0) res0 = b.r0;
              else res1 = b.r0;
              res_cnt = res_cnt + 2'd1;
            end
          end
          if (s_tlast) begin
            if (err == ERR_NONE) begin
              if (s.mode == MODE_BLOCK) err = ERR_BLOCK;
              else if (s.mode == MODE_STRING) err = ERR_STRING;
            end
            if (res_cnt == 2'd2) res1 = finish(res1, err, s);
            else res0 = finish(res0, err, s);
            s = STATE_RESET;
          end
        end
      end
    end
    state_next = s;
  end

  // result queue: head at entry 0, shifts on pop, new results land after the survivors
  always_comb begin
    logic [CNT_W-1:0] base;
    base = count - CNT_W'(pop);
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i < QDEPTH - 1) q_next[i] = q[(i + 1) % QDEPTH];
      else q_next[i] = q[i];
      if (res_cnt != 2'd0 && base == CNT_W'(i)) q_next[i] = res0;
      if (res_cnt == 2'd2 && base + CNT_W'(1) == CNT_W'(i)) q_next[i] = res1;
    end
    count_next = base + CNT_W'(res_cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

  assign m_tdata = {2'b00, q[0].err_col, q[0].err_line, q[0].err_code,
                    q[0].tok_start, q[0].cls, q[0].data};
  assign m_tlast = q[0].last;

  `CBT_ASSERT_NXT(a_end_resets, clk, rst, accept && s_tlast, !state.held_valid && !state.error_seen && state.line == POS_W'(1), "end of source did not reset scan state")
  `CBT_ASSERT_IMP(a_err_is_last, clk, rst, m_tvalid && q[0].err_code != ERR_NONE, q[0].last, "error result without last")
  `CBT_ASSERT_IMP(a_no_hold_in_err, clk, rst, state.error_seen, !state.held_valid, "byte held while dropping after error")
  `CBT_ASSERT_IMP(a_queue_bound, clk, rst, 1'b1, count <= CNT_W'(QDEPTH), "result queue overflow")

endmodule

@@ test/c_style_byte_tokenizer_top_tb.sv @@
`timescale 1ns / 1ps

module c_style_byte_tokenizer_top_tb;
  import cbt_pkg::*;

  localparam int LIMIT       = 1_000_000;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    logic [7:0] b;
    logic       eos;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tlast;

  c_style_byte_tokenizer_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // stimulus tables
  string      word_set   = "abzAZ_09";
  string      join_set   = "'%&|.";
  string      punct_set  = "+-*/(){}[];,<>=!:";
  string      cmt_set    = "ab */\n";
  string      tricky_set = "/*\\'\"";
  string      pair_ops [13] = '{"==", "!=", "<=", ">=", "+=", "-=", "*=", "/=", "%=",
                                "&&", "||", "++", "--"};
  logic [7:0] blank_set [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

  beat_t      src_beats[$];
  logic [7:0] src_text[$];
  res_t       labels_due[$];

  bit idle_on = 1'b1;
  int gap_left, stall_left, hold_left, n_drained;
  bit hold_done;
  int n_fail, n_bytes, n_sources, n_results, n_err_reports;
  int cycles;

  // tokenizer state as predicted
  scan_mode_t       mode;
  logic             q_single;
  logic [7:0]       held;
  logic             held_v;
  logic [POS_W-1:0] ln, cl, op_ln, op_cl;
  logic             dropping;

  function automatic void reset_scan();
    mode     = MODE_NORMAL;
    q_single = 1'b0;
    held     = 8'h00;
    held_v   = 1'b0;
    ln       = 1;
    cl       = 1;
    op_ln    = 1;
    op_cl    = 1;
    dropping = 1'b0;
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF ||
           c == CH_CR;
  endfunction

  function automatic bit is_punct(logic [7:0] c);
    case (c)
      "+", "-", "*", "/", "(", ")", "{", "}", "[", "]", ";", ",", "<", ">", "=", "!", ":":
        return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit is_pair(logic [7:0] a, logic [7:0] b);
    if (b == CH_EQ) begin
      case (a)
        "=", "!", "<", ">", "+", "-", "*", "/", CH_PCT: return 1'b1;
        default: return 1'b0;
      endcase
    end
    return a == b && (a == "&" || a == "|" || a == "+" || a == "-");
  endfunction

  // queue one labeled byte and advance the source position past it
  function automatic void emit(logic [7:0] c, byte_class_t cls, logic start);
    res_t r;
    r           = '0;
    r.data      = c;
    r.cls       = cls;
    r.tok_start = start;
    r.err_code  = ERR_NONE;
    labels_due = {labels_due, r};
    if (c == CH_LF) begin
      if (ln != {POS_W{1'b1}}) ln++;
      cl = 1;
    end else if (cl != {POS_W{1'b1}}) begin
      cl++;
    end
  endfunction

  // label byte c with optional lookahead n; took says n was consumed as well
  function automatic void label_byte(logic [7:0] c, bit has_n, logic [7:0] n,
                                     output bit took, output err_code_t err);
    took = 1'b0;
    err  = ERR_NONE;
    case (mode)
      MODE_LINE: begin
        if (c != CH_LF) begin
          emit(c, CLS_COMMENT, 1'b0);
          return;
        end
      end
      MODE_WORD: begin
        if (!(is_space(c) || c == CH_DQUOTE || is_punct(c))) begin
          emit(c, CLS_WORD, 1'b0);
          return;
        end
      end
      MODE_BLOCK: begin
        emit(c, CLS_COMMENT, 1'b0);
        if (c == CH_STAR && has_n && n == CH_SLASH) begin
          emit(n, CLS_COMMENT, 1'b0);
          mode = MODE_NORMAL;
          took = 1'b1;
        end
        return;
      end
      MODE_STRING: begin
        // escapes stay raw: backslash and the next byte go out together
        if (c == CH_BSLASH && has_n) begin
          emit(c, CLS_STRING, 1'b0);
          emit(n, CLS_STRING, 1'b0);
          took = 1'b1;
          return;
        end
        if (c == (q_single ? CH_SQUOTE : CH_DQUOTE)) mode = MODE_NORMAL;
        else if (c == CH_LF) err = ERR_STRING;
        emit(c, CLS_STRING, 1'b0);
        return;
      end
      default: ;
    endcase

    mode = MODE_NORMAL;
    if (is_space(c)) begin
      emit(c, CLS_SPACE, 1'b0);
    end else if (c == CH_SLASH && has_n && (n == CH_SLASH || n == CH_STAR)) begin
      if (n == CH_STAR) begin
        op_ln = ln;
        op_cl = cl;
        mode  = MODE_BLOCK;
      end else begin
        mode = MODE_LINE;
      end
      emit(c, CLS_COMMENT, 1'b0);
      emit(n, CLS_COMMENT, 1'b0);
      took = 1'b1;
    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      op_ln    = ln;
      op_cl    = cl;
      q_single = (c == CH_SQUOTE);
      mode     = MODE_STRING;
      emit(c, CLS_STRING, 1'b1);
    end else if (has_n && is_pair(c, n)) begin
      emit(c, CLS_PAIR_OP, 1'b1);
      emit(n, CLS_PAIR_OP, 1'b0);
      took = 1'b1;
    end else if (is_punct(c)) begin
      emit(c, CLS_PUNCT, 1'b1);
    end else begin
      mode = MODE_WORD;
      emit(c, CLS_WORD, 1'b1);
    end
  endfunction

  // tag the newest label as the final one of a source or of an error
  function automatic void close_out(err_code_t code);
    int k;
    k = labels_due.size() - 1;
    labels_due[k].err_code = code;
    if (code != ERR_NONE) begin
      labels_due[k].err_line = op_ln;
      labels_due[k].err_col  = op_cl;
    end
    labels_due[k].last = 1'b1;
  endfunction

  function automatic void predict_beat(logic [7:0] c, logic eos);
    bit        took;
    err_code_t err;
    took = 1'b0;
    err  = ERR_NONE;
    if (dropping) begin
      if (eos) reset_scan();
      return;
    end
    if (held_v) begin
      held_v = 1'b0;
      label_byte(held, 1'b1, c, took, err);
      if (err != ERR_NONE) begin
        close_out(err);
        if (eos) reset_scan();
        else dropping = 1'b1;
        return;
      end
    end
    if (!took) begin
      if (!eos) begin
        held   = c;
        held_v = 1'b1;
        return;
      end
      label_byte(c, 1'b0, 8'h00, took, err);
    end
    if (eos) begin
      if (err == ERR_NONE) begin
        if (mode == MODE_BLOCK) err = ERR_BLOCK;
        else if (mode == MODE_STRING) err = ERR_STRING;
      end
      close_out(err);
      reset_scan();
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      n_fail++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  task automatic put_ch(logic [7:0] c);
    src_text = {src_text, c};
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) src_text = {src_text, s[i]};
  endtask

  // turn the text built so far into one source, end flag on its final byte
  task automatic close_source();
    beat_t bt;
    foreach (src_text[i]) begin
      bt.b   = src_text[i];
      bt.eos = (i == src_text.size() - 1);
      src_beats = {src_beats, bt};
    end
    n_bytes += src_text.size();
    n_sources++;
    src_text.delete();
  endtask

  // one random source built from mostly well-formed tokens
  task automatic add_random_source();
    int         k;
    logic [7:0] q;
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          k = $urandom_range(1, 6);
          repeat (k) begin
            case ($urandom_range(0, 7))
              0: put_ch(8'($urandom_range(128, 255)));
              1: put_ch(join_set[$urandom_range(0, join_set.len() - 1)]);
              default: put_ch(word_set[$urandom_range(0, word_set.len() - 1)]);
            endcase
          end
        end
        2: put_ch(blank_set[$urandom_range(0, 5)]);
        3: put_ch(punct_set[$urandom_range(0, punct_set.len() - 1)]);
        4: put_str(pair_ops[$urandom_range(0, 12)]);
        5: begin
          q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
          put_ch(q);
          repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 3) == 0) begin
              put_ch(CH_BSLASH);
              put_ch(8'($urandom_range(0, 255)));
            end else begin
              put_ch(8'($urandom_range(32, 126)));
            end
          end
          if ($urandom_range(0, 7) != 0) put_ch(q);
        end
        6: begin
          put_str("//");
          repeat ($urandom_range(0, 6)) put_ch(8'($urandom_range(32, 126)));
          put_ch(CH_LF);
        end
        7: begin
          put_str("/*");
          repeat ($urandom_range(0, 8)) put_ch(cmt_set[$urandom_range(0, cmt_set.len() - 1)]);
          if ($urandom_range(0, 7) != 0) put_str("*/");
        end
        8: put_ch(8'($urandom_range(0, 255)));
        default: put_ch(tricky_set[$urandom_range(0, tricky_set.len() - 1)]);
      endcase
    end
    close_source();
  endtask

  // input driver
  always @(posedge clk) begin
    bit stuck;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      stuck = s_tvalid && !s_tready;
      if (s_tvalid && s_tready) void'(src_beats.pop_front());
      if (!stuck) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 5);
          s_tvalid <= 1'b0;
        end else if (src_beats.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= src_beats[0].b;
          s_tlast  <= src_beats[0].eos;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output ready: random stalls plus one long hold-off to back up the block
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) n_drained++;
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && n_drained >= 100) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 5);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // monitor: predict on input beats, check output beats
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      reset_scan();
    end else begin
      if (s_tvalid && s_tready) predict_beat(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        n_results++;
        if (labels_due.size() == 0) begin
          n_fail++;
          $error("output beat with nothing expected: tdata=%h tlast=%b", m_tdata, m_tlast);
        end else begin
          want = labels_due.pop_front();
          if (want.err_code != ERR_NONE) n_err_reports++;
          check_field("out_byte", want.data, m_tdata[7:0]);
          check_field("byte_class", want.cls, m_tdata[10:8]);
          check_field("token_start", want.tok_start, m_tdata[11]);
          check_field("error_code", want.err_code, m_tdata[13:12]);
          check_field("error_line", want.err_line, m_tdata[29:14]);
          check_field("error_column", want.err_col, m_tdata[45:30]);
          check_field("last", want.last, m_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d labels still due", cycles, labels_due.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    // word joiners, high byte, tab, line comment, escaped quote, %= and a final slash
    put_str("a'%.&|");
    put_ch(8'hFF);
    put_ch(CH_TAB);
    put_str("//c");
    put_ch(CH_LF);
    put_ch(CH_DQUOTE);
    put_ch(CH_BSLASH);
    put_ch(CH_DQUOTE);
    put_ch(CH_DQUOTE);
    put_str("%=/");
    close_source();
    // newline inside a single-quoted string, rest of source dropped
    put_ch(CH_SQUOTE);
    put_str("x");
    put_ch(CH_LF);
    put_str("zz");
    close_source();
    // source ends in an open block comment
    put_str("/*");
    close_source();
    // backslash as the last byte of a string
    put_ch(CH_DQUOTE);
    put_ch(CH_BSLASH);
    close_source();
    put_ch(8'h00);
    close_source();

    while (n_bytes < 1200) add_random_source();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (src_beats.size() != 0) @(negedge clk);
    idle_on = 1'b0;

    // closing stretch with both sides running flat out
    while (n_bytes < 1350) add_random_source();

    while (src_beats.size() != 0 || labels_due.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("%0d sources, %0d bytes; %0d labels checked, %0d carrying an error",
             n_sources, n_bytes, n_results, n_err_reports);
    $display("covered comments, strings, escapes, pair ops, unclosed sources, a long hold-off");
    if (n_fail == 0 && labels_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
